// ----- hw/rtl/rmq_pkg.sv -----
// Shared constants, codes and pipeline types for the running-mean one-bit quantizer.
package rmq_pkg;

  localparam int MAX_CHANNELS = 1024;
  localparam int MAX_WINDOW   = 128;

  localparam int CH_W   = 10;
  localparam int NC_W   = 11;
  localparam int WS_W   = 8;
  localparam int VAL_W  = 8;
  localparam int SMP_W  = VAL_W + 1;
  localparam int SUM_W  = 16;
  localparam int IDX_W  = 24;

  localparam int CH_AW  = $clog2(MAX_CHANNELS);
  localparam int POS_W  = $clog2(MAX_WINDOW);
  localparam int PS_W   = ((POS_W > WS_W) ? POS_W : WS_W) + 1;
  localparam int SLOT_W = CH_AW + POS_W;
  localparam int WIN_DEPTH = 2 ** SLOT_W;
  localparam int PROD_W = SMP_W + WS_W;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = NC_W;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 1'd1;

  localparam logic [WS_W-1:0] WINDOW_SIZE_RST  = 8'd16;
  localparam logic [NC_W-1:0] NUM_CHANNELS_RST = 11'd1024;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;
  localparam logic HALF_FIRST  = 1'b0;
  localparam logic HALF_SECOND = 1'b1;

  typedef struct packed {
    logic                fh_we;
    logic                act_data;
    logic                act_flush;
    logic                emit;
    logic                sum_set;
    logic [CH_AW-1:0]    ch_addr;
    logic [SLOT_W-1:0]   slot_a;
    logic [SLOT_W-1:0]   slot_b;
    logic [VAL_W-1:0]    value;
    logic [WS_W-1:0]     w;
    logic [IDX_W-1:0]    sample_index;
    logic [CH_W-1:0]     out_channel;
  } rmq_cmd_t;

  typedef struct packed {
    logic                store_we;
    logic [SLOT_W-1:0]   store_addr;
    logic [SMP_W-1:0]    store_data;
    logic                sum_we;
    logic [CH_AW-1:0]    sum_addr;
    logic [SUM_W-1:0]    sum_data;
  } rmq_wr_t;

  typedef struct packed {
    logic [VAL_W-1:0]    first_half;
    logic [SMP_W-1:0]    oldest;
    logic [SMP_W-1:0]    mirrored;
    logic [SUM_W-1:0]    sum;
  } rmq_rd_t;

endpackage

// ----- hw/rtl/rmq_if.sv -----
// Valid/ready channel interfaces for input items and result items.
interface rmq_in_if
  import rmq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [CH_W-1:0]  channel;
  logic             half;
  logic [VAL_W-1:0] value;

  modport source(output valid, kind, channel, half, value, input ready);
  modport sink(input valid, kind, channel, half, value, output ready);
endinterface

interface rmq_out_if
  import rmq_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             bit_res;
  logic [IDX_W-1:0] sample_index;
  logic [CH_W-1:0]  out_channel;

  modport source(output valid, bit_res, sample_index, out_channel, input ready);
  modport sink(input valid, bit_res, sample_index, out_channel, output ready);
endinterface

// ----- hw/rtl/running_mean_one_bit_quantizer.sv -----
// Top level of the running-mean one-bit quantizer.
//
//   Port       Dir   Handshake      Carries
//   in_item    in    valid/ready    kind, channel, half, value
//   out_res    out   valid/ready    bit_res, sample_index, out_channel
//   cfg_*      in    cfg_we only    cfg_index selects window_size or num_channels
//
// One item is accepted every cycle while no held result stalls the pipeline.
// The pipeline is the input register, the store read stage and the result register.
// A held result with out_res.ready low stalls the whole pipeline and drops in_item.ready.
// Reset clears control state only; the stores need no clearing pass and take items at once.
module running_mean_one_bit_quantizer
  import rmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rmq_in_if.sink                in_item,
  rmq_out_if.source             out_res
);

  logic     en;
  rmq_cmd_t cmd;
  rmq_wr_t  wr;
  rmq_rd_t  rd;

  rmq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .cmd       (cmd)
  );

  rmq_mem u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cmd   (cmd),
    .wr    (wr),
    .rd    (rd)
  );

  rmq_eval u_eval (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .rd      (rd),
    .wr      (wr),
    .en      (en),
    .out_res (out_res)
  );

endmodule

// ----- hw/rtl/rmq_ctrl.sv -----
// Configuration registers, input register, stream state and per-item command decode.
module rmq_ctrl
  import rmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rmq_in_if.sink                in_item,
  output rmq_cmd_t              cmd
);

  logic [WS_W-1:0]  window_size_r;
  logic [NC_W-1:0]  num_channels_r;

  logic             s0_v_r;
  logic             s0_kind_r;
  logic [CH_W-1:0]  s0_ch_r;
  logic             s0_half_r;
  logic [VAL_W-1:0] s0_val_r;

  logic [IDX_W-1:0] sample_count_r;
  logic [POS_W-1:0] ring_pos_r;
  logic [WS_W-1:0]  flush_step_r;
  logic             filled_r;

  logic [WS_W-1:0]  w;
  logic [NC_W-1:0]  nc;
  logic [PS_W-1:0]  w_ext;
  logic [PS_W-1:0]  fs_ext;
  logic [PS_W-1:0]  pos;
  logic [PS_W-1:0]  hs_sum;
  logic [PS_W-1:0]  hs;
  logic [PS_W-1:0]  ms_sum;
  logic [PS_W-1:0]  ms;
  logic [PS_W-1:0]  pos_inc;
  logic [PS_W-1:0]  ring_nxt;
  logic [IDX_W-1:0] sample_count_nxt;
  logic             in_range;
  logic             last_ch;
  logic             flush_ok;
  logic             data_ok;
  logic             act_data;

  assign in_item.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r  <= WINDOW_SIZE_RST;
      num_channels_r <= NUM_CHANNELS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WINDOW_SIZE:  window_size_r  <= cfg_data[WS_W-1:0];
        CFG_NUM_CHANNELS: num_channels_r <= cfg_data[NC_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (en) begin
      s0_v_r <= in_item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_kind_r <= in_item.kind;
      s0_ch_r   <= in_item.channel;
      s0_half_r <= in_item.half;
      s0_val_r  <= in_item.value;
    end
  end

  always_comb begin
    if (window_size_r == '0) begin
      w = WS_W'(1);
    end else if (32'(window_size_r) > MAX_WINDOW) begin
      w = WS_W'(MAX_WINDOW);
    end else begin
      w = window_size_r;
    end
    if (num_channels_r == '0) begin
      nc = NC_W'(1);
    end else if (32'(num_channels_r) > MAX_CHANNELS) begin
      nc = NC_W'(MAX_CHANNELS);
    end else begin
      nc = num_channels_r;
    end
  end

  assign w_ext  = PS_W'(w);
  assign fs_ext = PS_W'(flush_step_r);
  assign pos    = (PS_W'(ring_pos_r) >= w_ext) ? '0 : PS_W'(ring_pos_r);

  assign hs_sum = pos + fs_ext;
  assign hs     = (hs_sum >= w_ext) ? hs_sum - w_ext : hs_sum;
  assign ms_sum = pos + w_ext - PS_W'(1) - fs_ext;
  assign ms     = (ms_sum >= w_ext) ? ms_sum - w_ext : ms_sum;

  assign pos_inc  = pos + PS_W'(1);
  assign ring_nxt = (pos_inc >= w_ext) ? '0 : pos_inc;
  assign sample_count_nxt = sample_count_r + IDX_W'(1);

  assign in_range = NC_W'(s0_ch_r) < nc;
  assign last_ch  = NC_W'(s0_ch_r) == (nc - NC_W'(1));
  assign flush_ok = s0_v_r && in_range && (s0_kind_r == KIND_FLUSH) && filled_r
                    && (flush_step_r < w);
  assign data_ok  = s0_v_r && in_range && (s0_kind_r == KIND_DATA) && (flush_step_r == '0);
  assign act_data = data_ok && (s0_half_r == HALF_SECOND);

  always_comb begin
    cmd.fh_we        = data_ok && (s0_half_r == HALF_FIRST);
    cmd.act_data     = act_data;
    cmd.act_flush    = flush_ok;
    cmd.emit         = flush_ok || (act_data && filled_r);
    cmd.sum_set      = act_data && !filled_r && (sample_count_r == '0);
    cmd.ch_addr      = CH_AW'(s0_ch_r);
    cmd.slot_a       = {CH_AW'(s0_ch_r), POS_W'(flush_ok ? hs : pos)};
    cmd.slot_b       = {CH_AW'(s0_ch_r), POS_W'(ms)};
    cmd.value        = s0_val_r;
    cmd.w            = w;
    cmd.sample_index = sample_count_r - IDX_W'(w)
                       + (flush_ok ? IDX_W'(flush_step_r) : IDX_W'(0));
    cmd.out_channel  = CH_W'(nc - NC_W'(1) - NC_W'(s0_ch_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= '0;
      ring_pos_r     <= '0;
      flush_step_r   <= '0;
      filled_r       <= 1'b0;
    end else if (en) begin
      if (act_data && last_ch) begin
        sample_count_r <= sample_count_nxt;
        ring_pos_r     <= POS_W'(ring_nxt);
        if (sample_count_nxt >= IDX_W'(w)) begin
          filled_r <= 1'b1;
        end
      end
      if (flush_ok && last_ch) begin
        flush_step_r <= flush_step_r + WS_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/rmq_mem.sv -----
// First-half, window and sum stores with registered reads and one-deep write forwarding.
module rmq_mem
  import rmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  rmq_cmd_t cmd,
  input  rmq_wr_t  wr,
  output rmq_rd_t  rd
);

  logic [VAL_W-1:0]  fh_mem  [MAX_CHANNELS];
  logic [SMP_W-1:0]  win_mem [WIN_DEPTH];
  logic [SUM_W-1:0]  sum_mem [MAX_CHANNELS];

  logic [VAL_W-1:0]  fh_q_r;
  logic [SMP_W-1:0]  oldest_q_r;
  logic [SMP_W-1:0]  mirr_q_r;
  logic [SUM_W-1:0]  sum_q_r;

  logic [SLOT_W-1:0] slot_a_r;
  logic [SLOT_W-1:0] slot_b_r;
  logic [CH_AW-1:0]  ch_r;

  logic              byp_store_v_r;
  logic [SLOT_W-1:0] byp_store_addr_r;
  logic [SMP_W-1:0]  byp_store_data_r;
  logic              byp_sum_v_r;
  logic [CH_AW-1:0]  byp_sum_addr_r;
  logic [SUM_W-1:0]  byp_sum_data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (cmd.fh_we) begin
        fh_mem[cmd.ch_addr] <= cmd.value;
      end
      fh_q_r <= fh_mem[cmd.ch_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr.store_we) begin
        win_mem[wr.store_addr] <= wr.store_data;
      end
      oldest_q_r <= win_mem[cmd.slot_a];
      mirr_q_r   <= win_mem[cmd.slot_b];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (wr.sum_we) begin
        sum_mem[wr.sum_addr] <= wr.sum_data;
      end
      sum_q_r <= sum_mem[cmd.ch_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_store_v_r <= 1'b0;
      byp_sum_v_r   <= 1'b0;
    end else if (en) begin
      byp_store_v_r <= wr.store_we;
      byp_sum_v_r   <= wr.sum_we;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      byp_store_addr_r <= wr.store_addr;
      byp_store_data_r <= wr.store_data;
      byp_sum_addr_r   <= wr.sum_addr;
      byp_sum_data_r   <= wr.sum_data;
      slot_a_r         <= cmd.slot_a;
      slot_b_r         <= cmd.slot_b;
      ch_r             <= cmd.ch_addr;
    end
  end

  // A write at the same edge as the read is not seen by the array read.
  always_comb begin
    rd.first_half = fh_q_r;
    rd.oldest     = (byp_store_v_r && (byp_store_addr_r == slot_a_r)) ?
                    byp_store_data_r : oldest_q_r;
    rd.mirrored   = (byp_store_v_r && (byp_store_addr_r == slot_b_r)) ?
                    byp_store_data_r : mirr_q_r;
    rd.sum        = (byp_sum_v_r && (byp_sum_addr_r == ch_r)) ?
                    byp_sum_data_r : sum_q_r;
  end

endmodule

// ----- hw/rtl/rmq_eval.sv -----
// Compare against the window mean, store and sum update, and the result register.
module rmq_eval
  import rmq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  rmq_cmd_t cmd,
  input  rmq_rd_t  rd,
  output rmq_wr_t  wr,
  output logic     en,
  rmq_out_if.source out_res
);

  logic             s1_v_r;
  rmq_cmd_t         s1_cmd_r;

  logic             out_valid_r;
  logic             out_bit_r;
  logic [IDX_W-1:0] out_index_r;
  logic [CH_W-1:0]  out_channel_r;

  logic             act_data;
  logic             act_flush;
  logic [SMP_W-1:0] smp;
  logic [SMP_W-1:0] new_v;
  logic [PROD_W-1:0] prod;
  logic             bit_res;
  logic [SUM_W-1:0] sum_nxt;

  assign en = !out_valid_r || out_res.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= cmd.act_data || cmd.act_flush;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cmd_r <= cmd;
    end
  end

  assign act_data  = s1_v_r && s1_cmd_r.act_data;
  assign act_flush = s1_v_r && s1_cmd_r.act_flush;

  assign smp     = SMP_W'(rd.first_half) + SMP_W'(s1_cmd_r.value);
  assign new_v   = act_flush ? rd.mirrored : smp;
  assign prod    = PROD_W'(rd.oldest) * PROD_W'(s1_cmd_r.w);
  assign bit_res = prod > PROD_W'(rd.sum);

  always_comb begin
    if (s1_cmd_r.sum_set) begin
      sum_nxt = SUM_W'(smp);
    end else if (s1_cmd_r.emit) begin
      sum_nxt = rd.sum + SUM_W'(new_v) - SUM_W'(rd.oldest);
    end else begin
      sum_nxt = rd.sum + SUM_W'(new_v);
    end
  end

  always_comb begin
    wr.store_we   = act_data;
    wr.store_addr = s1_cmd_r.slot_a;
    wr.store_data = smp;
    wr.sum_we     = act_data || act_flush;
    wr.sum_addr   = s1_cmd_r.ch_addr;
    wr.sum_data   = sum_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s1_v_r && s1_cmd_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bit_r     <= bit_res;
      out_index_r   <= s1_cmd_r.sample_index;
      out_channel_r <= s1_cmd_r.out_channel;
    end
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.bit_res      = out_bit_r;
  assign out_res.sample_index = out_index_r;
  assign out_res.out_channel  = out_channel_r;

endmodule

// ----- tb/quant_bit_checker.sv -----
// Checker that models every accepted item, predicts the bit of each one that yields a result and compares each result.
module quant_bit_checker
  import rmq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rmq_in_if                     in_mon,
  rmq_out_if                    out_mon,
  output int                    fault_count,
  output int                    bits_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             bit_res;
    logic [IDX_W-1:0] sample_index;
    logic [CH_W-1:0]  out_channel;
  } quant_bit_t;

  logic [VAL_W-1:0] row_byte   [MAX_CHANNELS];
  logic [SMP_W-1:0] pair_ring  [WIN_DEPTH];
  logic [SUM_W-1:0] pair_total [MAX_CHANNELS];
  logic [IDX_W-1:0] pairs_done;
  logic [POS_W-1:0] ring_head;
  logic [WS_W-1:0]  flush_done;
  logic             window_full;
  logic [WS_W-1:0]  window_reg;
  logic [NC_W-1:0]  chans_reg;
  quant_bit_t       due_bits [$];
  quant_bit_t       seen;

  function automatic void quantize_item(input logic kind, input logic [CH_W-1:0] ch,
                                        input logic half, input logic [VAL_W-1:0] val);
    int unsigned w, nc, pos, hs, ms, oldest, mirrored, pair, slot;
    quant_bit_t  bit_item;
    w  = (window_reg == 0) ? 1 : (window_reg > MAX_WINDOW) ? MAX_WINDOW : window_reg;
    nc = (chans_reg == 0) ? 1 : (chans_reg > MAX_CHANNELS) ? MAX_CHANNELS : chans_reg;
    if (ch >= nc) return;
    pos = 32'(ring_head);
    if (pos >= w) pos = 0;

    if (kind == KIND_FLUSH) begin
      if (!window_full || flush_done >= w) return;
      hs = (pos + flush_done) % w;
      ms = (pos + w - 1 - flush_done) % w;
      oldest   = 32'(pair_ring[ch * MAX_WINDOW + hs]);
      mirrored = 32'(pair_ring[ch * MAX_WINDOW + ms]);
      bit_item.bit_res      = (oldest * w > pair_total[ch]);
      bit_item.sample_index = IDX_W'(pairs_done - w + flush_done);
      bit_item.out_channel  = CH_W'(nc - 1 - ch);
      due_bits.push_back(bit_item);
      pair_total[ch] = SUM_W'(pair_total[ch] + mirrored - oldest);
      if (ch == nc - 1) flush_done = flush_done + WS_W'(1);
      return;
    end

    // Once the flush has begun, the data stream is closed until reset.
    if (flush_done != 0) return;
    if (half == HALF_FIRST) begin
      row_byte[ch] = val;
      return;
    end

    pair = 32'(row_byte[ch]) + 32'(val);
    slot = ch * MAX_WINDOW + pos;
    if (window_full) begin
      oldest = 32'(pair_ring[slot]);
      bit_item.bit_res      = (oldest * w > pair_total[ch]);
      bit_item.sample_index = IDX_W'(pairs_done - w);
      bit_item.out_channel  = CH_W'(nc - 1 - ch);
      due_bits.push_back(bit_item);
      pair_total[ch] = SUM_W'(pair_total[ch] + pair - oldest);
    end else if (pairs_done == 0) begin
      pair_total[ch] = SUM_W'(pair);
    end else begin
      pair_total[ch] = SUM_W'(pair_total[ch] + pair);
    end
    pair_ring[slot] = SMP_W'(pair);

    if (ch == nc - 1) begin
      pairs_done = pairs_done + IDX_W'(1);
      pos = pos + 1;
      if (pos >= w) pos = 0;
      ring_head = POS_W'(pos);
      if (pairs_done >= w) window_full = 1'b1;
    end
  endfunction

  function automatic void check_bit(input quant_bit_t got);
    quant_bit_t want;
    if (due_bits.size() == 0) begin
      $error("unexpected result: bit_res %0d sample_index %0d out_channel %0d",
             got.bit_res, got.sample_index, got.out_channel);
      fault_count++;
      return;
    end
    want = due_bits.pop_front();
    if (got.bit_res !== want.bit_res) begin
      $error("bit_res expected %0d actual %0d", want.bit_res, got.bit_res);
      fault_count++;
    end
    if (got.sample_index !== want.sample_index) begin
      $error("sample_index expected %0d actual %0d", want.sample_index, got.sample_index);
      fault_count++;
    end
    if (got.out_channel !== want.out_channel) begin
      $error("out_channel expected %0d actual %0d", want.out_channel, got.out_channel);
      fault_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      window_reg  = WINDOW_SIZE_RST;
      chans_reg   = NUM_CHANNELS_RST;
      pairs_done  = '0;
      ring_head   = '0;
      flush_done  = '0;
      window_full = 1'b0;
      due_bits.delete();
      fault_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WINDOW_SIZE:  window_reg = cfg_data[WS_W-1:0];
          CFG_NUM_CHANNELS: chans_reg  = cfg_data[NC_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) begin
        quantize_item(in_mon.kind, in_mon.channel, in_mon.half, in_mon.value);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen.bit_res      = out_mon.bit_res;
        seen.sample_index = out_mon.sample_index;
        seen.out_channel  = out_mon.out_channel;
        check_bit(seen);
      end
    end
    bits_owed = due_bits.size();
  end

endmodule

// ----- tb/testbench.sv -----
// Top of the quantizer testbench: clock, reset, register setup, item stimulus and verdict.
module testbench
  import rmq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOP_CH = MAX_CHANNELS - 1;

  typedef enum {RX_OPEN, RX_JITTER, RX_BEAT} rx_mode_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fault_count;
  int                    bits_owed;

  rmq_in_if  in_item();
  rmq_out_if out_res();

  running_mean_one_bit_quantizer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_res   (out_res)
  );

  quant_bit_checker bit_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mon      (in_item),
    .out_mon     (out_res),
    .fault_count (fault_count),
    .bits_owed   (bits_owed)
  );

  int          burst_left;
  bit          steady;
  bit          want_hold;
  int unsigned cur_nc;
  int          live_chans [$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : receiver
    int       seg_left, hold_left, tick, period, low_len;
    rx_mode_t mode;
    seg_left  = 0;
    hold_left = 0;
    tick      = 0;
    period    = 2;
    low_len   = 1;
    mode      = RX_OPEN;
    out_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold) begin
        want_hold = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_res.ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(300, 30);
          mode     = rx_mode_t'($urandom_range(2, 0));
          period   = $urandom_range(9, 2);
          low_len  = $urandom_range(period - 1, 1);
          tick     = 0;
        end
        seg_left--;
        tick++;
        case (mode)
          RX_OPEN:   out_res.ready <= 1'b1;
          RX_JITTER: out_res.ready <= ($urandom_range(3, 0) != 0);
          default:   out_res.ready <= ((tick % period) >= low_len);
        endcase
      end
    end
  end

  function automatic logic [VAL_W-1:0] pick_byte();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      default: return VAL_W'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic offer_item(input logic kind, input logic [CH_W-1:0] ch,
                            input logic half, input logic [VAL_W-1:0] val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(24, 1);
      gap = steady ? 0 : $urandom_range(6, 0);
      if (gap > 0) begin
        in_item.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_item.valid   <= 1'b1;
    in_item.kind    <= kind;
    in_item.channel <= ch;
    in_item.half    <= half;
    in_item.value   <= val;
    do @(posedge clk); while (!in_item.ready);
    burst_left--;
  endtask

  task automatic settle();
    int waited;
    in_item.valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    @(posedge clk);
    while (bits_owed != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic apply_setting(input int unsigned w, input int unsigned nc);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WINDOW_SIZE;
    cfg_data  <= CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= CFG_NUM_CHANNELS;
    cfg_data  <= CFG_DATA_W'(nc);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_nc = nc;
    // Only these channels ever get a complete window, so only they may see a
    // second row or a flush.
    live_chans.delete();
    for (int c = 0; c < 3; c++) begin
      if (c < nc) live_chans.push_back(c);
    end
    if (nc == MAX_CHANNELS) live_chans.push_back(TOP_CH);
  endtask

  task automatic send_sample(input int fixed);
    foreach (live_chans[i]) begin
      offer_item(KIND_DATA, CH_W'(live_chans[i]), HALF_FIRST,
                 (fixed < 0) ? pick_byte() : VAL_W'(fixed));
    end
    foreach (live_chans[i]) begin
      offer_item(KIND_DATA, CH_W'(live_chans[i]), HALF_SECOND,
                 (fixed < 0) ? pick_byte() : VAL_W'(fixed));
    end
  endtask

  task automatic send_noise();
    int pick;
    pick = live_chans[$urandom_range(live_chans.size() - 1, 0)];
    case ($urandom_range(3, 0))
      0: begin
        if (cur_nc < MAX_CHANNELS) begin
          offer_item(1'($urandom_range(1, 0)), CH_W'($urandom_range(TOP_CH, cur_nc)),
                     1'($urandom_range(1, 0)), pick_byte());
        end else begin
          offer_item(KIND_DATA, CH_W'($urandom_range(TOP_CH, 0)), HALF_FIRST, pick_byte());
        end
      end
      1: offer_item(KIND_DATA, CH_W'($urandom_range(cur_nc - 1, 0)), HALF_FIRST, pick_byte());
      2: offer_item(KIND_DATA, CH_W'(pick), HALF_SECOND, pick_byte());
      default: offer_item(KIND_DATA, CH_W'(pick), HALF_FIRST, pick_byte());
    endcase
  endtask

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int          budget, rounds;
    int unsigned w, nc;
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_index       <= CFG_WINDOW_SIZE;
    cfg_data        <= '0;
    in_item.valid   <= 1'b0;
    in_item.kind    <= KIND_DATA;
    in_item.channel <= '0;
    in_item.half    <= HALF_FIRST;
    in_item.value   <= '0;
    burst_left = 0;
    steady     = 1'b0;
    want_hold  = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Widest window over the full channel range, so that every slot of every
    // live channel is written before the first comparison reads it.
    apply_setting(MAX_WINDOW, MAX_CHANNELS);
    offer_item(KIND_FLUSH, '0, HALF_FIRST, '0);
    offer_item(KIND_FLUSH, CH_W'(TOP_CH), HALF_SECOND, '1);
    send_sample(255);
    send_sample(0);
    for (int s = 2; s < MAX_WINDOW + 3; s++) send_sample(-1);

    // Window shrunk mid-stream to a single sample on a single channel.
    apply_setting(1, 1);
    offer_item(KIND_DATA, CH_W'(TOP_CH), HALF_SECOND, '1);
    offer_item(KIND_FLUSH, CH_W'(512), HALF_FIRST, '0);
    send_sample(255);
    send_sample(0);
    send_sample(-1);

    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(3, 0))
        0:       w = 1;
        1:       w = MAX_WINDOW;
        default: w = $urandom_range(MAX_WINDOW, 1);
      endcase
      case ($urandom_range(5, 0))
        0:       nc = 1;
        1:       nc = 2;
        2:       nc = 3;
        3:       nc = MAX_CHANNELS;
        default: nc = $urandom_range(TOP_CH, 4);
      endcase
      steady = ($urandom_range(3, 0) == 0);
      apply_setting(w, nc);
      if (phase == 1) want_hold = 1'b1;
      budget = 0;
      while (budget < 80) begin
        if ($urandom_range(9, 0) < 8) begin
          send_sample(-1);
          budget += 2 * live_chans.size();
        end else begin
          send_noise();
          budget++;
        end
      end
    end

    case ($urandom_range(3, 0))
      0:       w = 1;
      1:       w = MAX_WINDOW;
      default: w = $urandom_range(40, 1);
    endcase
    case ($urandom_range(2, 0))
      0:       nc = 1;
      1:       nc = 3;
      default: nc = MAX_CHANNELS;
    endcase
    steady = 1'b0;
    apply_setting(w, nc);
    // Two rounds beyond the window check that surplus flush items stay silent.
    rounds = w + 2;
    for (int r = 0; r < rounds; r++) begin
      foreach (live_chans[i]) begin
        offer_item(KIND_FLUSH, CH_W'(live_chans[i]), 1'($urandom_range(1, 0)), pick_byte());
      end
      if (r > 0 && $urandom_range(3, 0) == 0) begin
        offer_item(KIND_DATA, CH_W'(live_chans[0]), 1'($urandom_range(1, 0)), pick_byte());
      end
      if (nc < MAX_CHANNELS && $urandom_range(3, 0) == 0) begin
        offer_item(KIND_FLUSH, CH_W'($urandom_range(TOP_CH, nc)), HALF_FIRST, pick_byte());
      end
    end

    settle();
    if (bits_owed != 0) $error("%0d expected results never arrived", bits_owed);
    if (fault_count == 0 && bits_owed == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
